### hw/rtl/rdad_pkg.sv
// shared types and constants for the rtt delay anomaly detector
package rdad_pkg;

  // result status codes
  typedef enum logic [2:0] {
    STAT_TIMEOUT  = 3'd0,
    STAT_STARTUP  = 3'd1,
    STAT_BASELINE = 3'd2,
    STAT_NORMAL   = 3'd3,
    STAT_ANOMALY  = 3'd4
  } status_t;

  // configuration register indexes
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_LIMIT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANOMALY_MULT  = 8'd1;

  localparam logic [31:0] STARTUP_LIMIT_RST = 32'd2000;
  localparam logic [3:0]  ANOMALY_MULT_RST  = 4'd4;

  // tick to millisecond conversion
  localparam logic [9:0] MS_PER_SECOND = 10'd1000;

  localparam int TH_W = 36;

  // one node's statistics entry
  typedef struct packed {
    logic [31:0] srtt;
    logic [31:0] rttvar;
  } stat_t;

  // read response of the statistics table
  typedef struct packed {
    stat_t stat;
    logic  init;
  } stat_rd_t;

endpackage

### hw/rtl/rdad_rtt_conv.sv
// converts a tick difference to milliseconds with reciprocal multiplication
module rdad_rtt_conv import rdad_pkg::*; #(
  parameter int TICKS_PER_SECOND = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] send_tick,
  input  logic [31:0] reply_tick,
  output logic        done,
  output logic [31:0] rtt_ms
);

  // floor(x / TICKS_PER_SECOND) for any 32-bit x is (x * RECIP) >> RECIP_SH
  localparam int RECIP_SH = 32 + $clog2(TICKS_PER_SECOND);
  localparam logic [32:0] RECIP =
    33'(((64'd1 << RECIP_SH) + 64'(TICKS_PER_SECOND) - 64'd1) / 64'(TICKS_PER_SECOND));
  localparam logic [31:0] TICKS = 32'(TICKS_PER_SECOND);

  typedef enum logic [5:0] {
    CV_IDLE  = 6'b000001,
    CV_QUOT  = 6'b000010,
    CV_REM   = 6'b000100,
    CV_SCALE = 6'b001000,
    CV_FRAC  = 6'b010000,
    CV_SUM   = 6'b100000
  } conv_state_t;

  conv_state_t  cstate;
  logic [31:0]  diff;
  logic [31:0]  diff_q;
  logic [31:0]  x;
  logic [31:0]  whole_q;
  logic [31:0]  rem_q;
  logic [31:0]  frac_q;
  logic [64:0]  recip_prod;
  logic [31:0]  quot;
  logic [41:0]  ms_full;

  assign diff       = reply_tick - send_tick;
  assign recip_prod = 65'(x) * 65'(RECIP);
  assign quot       = 32'(recip_prod >> RECIP_SH);

  // diff*1000/T split as whole seconds of ticks and the leftover ticks
  assign ms_full = 42'(whole_q) * 42'(MS_PER_SECOND) + 42'(frac_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      cstate <= CV_IDLE;
      done   <= 1'b0;
    end else begin
      unique case (cstate)
        CV_IDLE: begin
          done <= 1'b0;
          if (start) begin
            diff_q <= diff;
            x      <= diff;
            cstate <= CV_QUOT;
          end
        end
        CV_QUOT: begin
          whole_q <= quot;
          cstate  <= CV_REM;
        end
        CV_REM: begin
          rem_q  <= diff_q - whole_q * TICKS;
          cstate <= CV_SCALE;
        end
        CV_SCALE: begin
          // leftover ticks times 1000 stays below 2^30
          x      <= rem_q * 32'(MS_PER_SECOND);
          cstate <= CV_FRAC;
        end
        CV_FRAC: begin
          frac_q <= quot;
          cstate <= CV_SUM;
        end
        CV_SUM: begin
          done   <= 1'b1;
          // saturate to 32 bits
          rtt_ms <= (|ms_full[41:32]) ? 32'hFFFF_FFFF : ms_full[31:0];
          cstate <= CV_IDLE;
        end
        default: cstate <= CV_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/rdad_stat_mem.sv
// per-node statistics memory with init flags
module rdad_stat_mem import rdad_pkg::*; #(
  parameter int NODES = 2,
  parameter int IDX_W = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output stat_rd_t         rd_data,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  stat_t            wr_data
);

  stat_t            mem [NODES];
  logic [NODES-1:0] init;
  stat_t            rd_stat;
  logic             rd_init;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_stat <= mem[rd_addr];
    end
  end

  // an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      init    <= '0;
      rd_init <= 1'b0;
    end else begin
      if (wr_en) begin
        init[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_init <= init[rd_addr];
      end
    end
  end

  assign rd_data.init = rd_init;
  assign rd_data.stat = rd_init ? rd_stat : '0;

endmodule

### hw/rtl/rtt_delay_anomaly_detector.sv
// top level of the rtt delay anomaly detector
//
//  channel  dir  handshake           payload
//  s_*      in   s_tvalid/s_tready   tuser: timed_out, node; tdata: send_tick, reply_tick
//  m_*      out  m_tvalid/m_tready   tuser: status; tdata: rtt_ms, srtt, rttvar, thresh, anomaly
//  cfg_*    in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// a reply goes through the tick to millisecond conversion (two reciprocal multiplies, steps
// quot, rem, scale, frac, sum) and then the table update (terms, upd, thresh, done); a timeout
// skips the conversion. the input is ready again in the same cycle as the result appears.
// one item at a time: the table entry is written back before the next item reads it.
// reset clears all node entries at once; the config port is always ready.
// a result waiting on m_tready holds the block in its last step.
module rtt_delay_anomaly_detector import rdad_pkg::*; #(
  parameter int NODES            = 2,
  parameter int TICKS_PER_SECOND = 128
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [63:0]          s_tdata,  // send_tick, reply_tick
  input  logic [1:0]           s_tuser,  // timed_out, node
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [135:0]         m_tdata,  // rtt_ms, smoothed_rtt, rtt_variation, threshold, anomaly
  output logic [2:0]           m_tuser,  // status
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int IDX_W = (NODES > 1) ? $clog2(NODES) : 1;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_CONV   = 6'b000010,
    ST_TERMS  = 6'b000100,
    ST_UPD    = 6'b001000,
    ST_THRESH = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  state_t state;

  logic [31:0]    startup_limit;
  logic [3:0]     anomaly_mult;

  logic           accept;
  logic [IDX_W-1:0] node_idx;
  logic           timed_out_q;
  logic [IDX_W-1:0] idx_q;
  logic [31:0]    rtt_q;

  logic           conv_done;
  logic [31:0]    conv_rtt;
  stat_rd_t       rd_data;
  stat_t          wr_data;
  logic           wr_en;

  logic [31:0]    s_term;
  logic [31:0]    v_term;
  logic [31:0]    delta_q;
  logic           too_slow;
  logic [31:0]    s_new;
  logic [31:0]    v_new;
  status_t        status_q;
  logic           upd_wr;
  logic           detect;
  logic [TH_W-1:0] th_q;
  logic           anom;
  logic           out_free;

  logic [34:0]    s_x7;
  logic [33:0]    v_x3;
  logic [31:0]    delta;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE);
  assign node_idx = (NODES > 1) ? IDX_W'(s_tuser[1]) : '0;
  assign out_free = !m_tvalid || m_tready;

  // configuration writes
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      startup_limit <= STARTUP_LIMIT_RST;
      anomaly_mult  <= ANOMALY_MULT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_STARTUP_LIMIT: startup_limit <= cfg_data;
        CFG_ANOMALY_MULT:  anomaly_mult  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  rdad_rtt_conv #(
    .TICKS_PER_SECOND(TICKS_PER_SECOND)
  ) u_conv (
    .clk        (clk),
    .rst        (rst),
    .start      (accept && !s_tuser[0]),
    .send_tick  (s_tdata[31:0]),
    .reply_tick (s_tdata[63:32]),
    .done       (conv_done),
    .rtt_ms     (conv_rtt)
  );

  assign wr_en          = (state == ST_DONE) && out_free && upd_wr;
  assign wr_data.srtt   = s_new;
  assign wr_data.rttvar = v_new;

  rdad_stat_mem #(
    .NODES(NODES),
    .IDX_W(IDX_W)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (node_idx),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (idx_q),
    .wr_data (wr_data)
  );

  // scaled terms of the estimator update
  assign s_x7  = {rd_data.stat.srtt, 3'b000} - 35'(rd_data.stat.srtt);
  assign v_x3  = {rd_data.stat.rttvar, 1'b0} + 34'(rd_data.stat.rttvar);
  assign delta = (rd_data.stat.srtt > rtt_q) ? rd_data.stat.srtt - rtt_q
                                             : rtt_q - rd_data.stat.srtt;
  assign anom  = detect && (TH_W'(rtt_q) > th_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= s_tuser[0] ? ST_TERMS : ST_CONV;
          end
        end
        ST_CONV: begin
          if (conv_done) begin
            state <= ST_TERMS;
          end
        end
        ST_TERMS:  state <= ST_UPD;
        ST_UPD:    state <= ST_THRESH;
        ST_THRESH: state <= ST_DONE;
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      timed_out_q <= s_tuser[0];
      idx_q       <= node_idx;
      rtt_q       <= '0;
    end
    if (state == ST_CONV && conv_done) begin
      rtt_q <= conv_rtt;
    end
    if (state == ST_TERMS) begin
      s_term   <= s_x7[34:3];
      v_term   <= v_x3[33:2];
      delta_q  <= {2'b00, delta[31:2]};
      too_slow <= rtt_q > startup_limit;
    end
    if (state == ST_UPD) begin
      if (timed_out_q) begin
        status_q <= STAT_TIMEOUT;
        s_new    <= rd_data.stat.srtt;
        v_new    <= rd_data.stat.rttvar;
        upd_wr   <= 1'b0;
        detect   <= 1'b0;
      end else if (!rd_data.init && too_slow) begin
        status_q <= STAT_STARTUP;
        s_new    <= rd_data.stat.srtt;
        v_new    <= rd_data.stat.rttvar;
        upd_wr   <= 1'b0;
        detect   <= 1'b0;
      end else if (!rd_data.init) begin
        status_q <= STAT_BASELINE;
        s_new    <= rtt_q;
        v_new    <= {1'b0, rtt_q[31:1]};
        upd_wr   <= 1'b1;
        detect   <= 1'b0;
      end else begin
        status_q <= STAT_NORMAL;
        s_new    <= s_term + {3'b000, rtt_q[31:3]};
        v_new    <= v_term + delta_q;
        upd_wr   <= 1'b1;
        detect   <= 1'b1;
      end
    end
    if (state == ST_THRESH) begin
      th_q <= detect ? TH_W'(s_new) + TH_W'(v_new) * TH_W'(anomaly_mult) : '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      m_tuser <= anom ? STAT_ANOMALY : status_q;
      m_tdata <= {3'b000, anom, th_q, v_new, s_new, rtt_q};
    end
  end

endmodule
